// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under a synchronous reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication under a synchronous reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hdl/shrc_pkg.sv -----
// shared types, constants and helpers of the strip hit run clustering core
`default_nettype none
package shrc_pkg;

   localparam int STRIPS_DEFAULT = 256;
   localparam int WORD_BITS = 32;
   localparam int WORD_LOG = 5;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_MARK  = 2'd1;
   localparam logic [1:0] ACT_FETCH = 2'd2;

   typedef struct packed {
      logic clear;
      logic mark;
      logic fetch;
      logic step;
      logic emit;
   } shrc_cmd_type;

   typedef struct packed {
      logic at_end;
      logic scan_done;
      logic out_free;
   } shrc_status_type;

   // lowest set bit: {hit, index}
   function automatic logic [WORD_LOG:0] first_set(input logic [WORD_BITS-1:0] v);
      logic [WORD_LOG:0] r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) r = {1'b1, WORD_LOG'(i)};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/shrc_ctrl.sv -----
// controller state machine of the strip hit run clustering core
`default_nettype none
module shrc_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [1:0]                 req_action,
   input  wire shrc_pkg::shrc_status_type  status,
   output shrc_pkg::shrc_cmd_type          cmd
);
   import shrc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (req_action)
                  ACT_CLEAR: cmd.clear = 1'b1;
                  ACT_MARK:  cmd.mark = 1'b1;
                  ACT_FETCH: begin
                     cmd.fetch = 1'b1;
                     state_in  = status.at_end ? ST_EMIT : ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (status.scan_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/shrc_datapath.sv -----
// hit map memory, scan registers and result register of the clustering core
`default_nettype none
module shrc_datapath #(
   parameter int STRIPS_PER_COLUMN = shrc_pkg::STRIPS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire shrc_pkg::shrc_cmd_type    cmd,
   output shrc_pkg::shrc_status_type      status,
   input  wire logic [9:0]                channel,
   input  wire logic                      rsp_tready,
   output logic                           rsp_tvalid,
   output logic                           rsp_found,
   output logic                           rsp_column,
   output logic [7:0]                     rsp_first_row,
   output logic [8:0]                     rsp_run_size,
   output logic [7:0]                     rsp_cluster_number
);
   import shrc_pkg::*;

   localparam int RW = $clog2(STRIPS_PER_COLUMN);
   localparam int WPC = (STRIPS_PER_COLUMN + WORD_BITS - 1) / WORD_BITS;
   localparam int WIDX_W = (WPC > 1) ? $clog2(WPC) : 1;
   localparam int AW = WIDX_W + 1;
   localparam int ROWS = 2 ** AW;

   logic [WORD_BITS-1:0] mem_ff [ROWS];
   logic [ROWS-1:0]      valid_ff, valid_in;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_valid_ff;

   logic          pos_col_ff, pos_col_in;
   logic [RW-1:0] pos_row_ff, pos_row_in;
   logic          pos_end_ff, pos_end_in;
   logic [8:0]    count_ff, count_in;

   logic              col_ff, col_in;
   logic [WIDX_W-1:0] word_ff, word_in;
   logic [WORD_LOG-1:0] start_ff, start_in;
   logic              run_ff, run_in;
   logic [RW:0]       first_ff, first_in;
   logic [RW:0]       end_ff, end_in;
   logic              found_ff, found_in;

   logic       out_valid_ff, out_valid_in;
   logic       out_found_ff, out_found_in;
   logic       out_col_ff, out_col_in;
   logic [7:0] out_row_ff, out_row_in;
   logic [8:0] out_size_ff, out_size_in;
   logic [7:0] out_num_ff, out_num_in;

   logic [12:0]          ch_ext, ch_pos;
   logic                 ch_ok, m_col;
   logic [RW-1:0]        m_row;
   logic [AW-1:0]        wr_addr;
   logic [WORD_LOG-1:0]  wr_bit;
   logic [WORD_BITS-1:0] word, sel;
   logic [WORD_LOG:0]    hit;
   logic                 last_word;
   logic [RW:0]          hit_row, diff;

   always_comb begin
      ch_ext  = 13'(channel);
      ch_ok   = (ch_ext != 13'd0) && (ch_ext <= 13'(2 * STRIPS_PER_COLUMN));
      ch_pos  = ch_ext - 13'd1;
      m_col   = ch_pos >= 13'(STRIPS_PER_COLUMN);
      m_row   = RW'(m_col ? ch_pos - 13'(STRIPS_PER_COLUMN) : ch_pos);
      wr_addr = {m_col, WIDX_W'(m_row >> WORD_LOG)};
      wr_bit  = WORD_LOG'(m_row);

      word      = rd_valid_ff ? rd_data_ff : '0;
      sel       = (run_ff ? ~word : word) & ({WORD_BITS{1'b1}} << start_ff);
      hit       = first_set(sel);
      last_word = word_ff == WIDX_W'(WPC - 1);
      hit_row   = (RW + 1)'({word_ff, hit[WORD_LOG-1:0]});
      diff      = end_ff - first_ff;
   end

   always_comb begin
      valid_in   = valid_ff;
      pos_col_in = pos_col_ff;
      pos_row_in = pos_row_ff;
      pos_end_in = pos_end_ff;
      count_in   = count_ff;
      col_in     = col_ff;
      word_in    = word_ff;
      start_in   = start_ff;
      run_in     = run_ff;
      first_in   = first_ff;
      end_in     = end_ff;
      found_in   = found_ff;
      status.at_end    = pos_end_ff;
      status.out_free  = !out_valid_ff || rsp_tready;
      status.scan_done = 1'b0;

      if (cmd.clear) begin
         valid_in   = '0;
         pos_col_in = 1'b0;
         pos_row_in = '0;
         pos_end_in = 1'b0;
         count_in   = '0;
      end
      if (cmd.mark && ch_ok) valid_in[wr_addr] = 1'b1;
      if (cmd.fetch) begin
         col_in   = pos_col_ff;
         word_in  = WIDX_W'(pos_row_ff >> WORD_LOG);
         start_in = WORD_LOG'(pos_row_ff);
         run_in   = 1'b0;
         found_in = 1'b0;
      end
      if (cmd.step) begin
         if (hit[WORD_LOG]) begin
            if (run_ff) begin
               end_in   = hit_row;
               found_in = 1'b1;
               status.scan_done = 1'b1;
            end else begin
               first_in = hit_row;
               start_in = hit[WORD_LOG-1:0];
               run_in   = 1'b1;
            end
         end else if (!last_word) begin
            word_in  = word_ff + WIDX_W'(1);
            start_in = '0;
         end else if (run_ff) begin
            end_in   = (RW + 1)'(STRIPS_PER_COLUMN);
            found_in = 1'b1;
            status.scan_done = 1'b1;
         end else if (!col_ff) begin
            col_in   = 1'b1;
            word_in  = '0;
            start_in = '0;
         end else begin
            found_in = 1'b0;
            status.scan_done = 1'b1;
         end
      end
      if (cmd.emit) begin
         if (found_ff) begin
            count_in = count_ff + 9'd1;
            if (end_ff == (RW + 1)'(STRIPS_PER_COLUMN)) begin
               pos_row_in = '0;
               if (col_ff) pos_end_in = 1'b1;
               else pos_col_in = 1'b1;
            end else begin
               pos_col_in = col_ff;
               pos_row_in = RW'(end_ff);
            end
         end else begin
            pos_end_in = 1'b1;
         end
      end
   end

   always_comb begin
      out_valid_in = rsp_tready ? 1'b0 : out_valid_ff;
      out_found_in = out_found_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_size_in  = out_size_ff;
      out_num_in   = out_num_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_found_in = found_ff;
         if (found_ff) begin
            out_col_in  = col_ff;
            out_row_in  = 8'(first_ff);
            out_size_in = (32'(diff) > 32'd511) ? 9'd511 : 9'(diff);
            out_num_in  = 8'(count_ff);
         end else begin
            out_col_in  = 1'b0;
            out_row_in  = '0;
            out_size_in = '0;
            out_num_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mark && ch_ok) begin
         if (valid_ff[wr_addr]) mem_ff[wr_addr][wr_bit] <= 1'b1;
         else mem_ff[wr_addr] <= WORD_BITS'(1) << wr_bit;
      end
      rd_data_ff  <= mem_ff[{col_in, word_in}];
      rd_valid_ff <= valid_in[{col_in, word_in}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         pos_col_ff   <= 1'b0;
         pos_row_ff   <= '0;
         pos_end_ff   <= 1'b0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         pos_col_ff   <= pos_col_in;
         pos_row_ff   <= pos_row_in;
         pos_end_ff   <= pos_end_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      word_ff      <= word_in;
      start_ff     <= start_in;
      run_ff       <= run_in;
      first_ff     <= first_in;
      end_ff       <= end_in;
      found_ff     <= found_in;
      out_found_ff <= out_found_in;
      out_col_ff   <= out_col_in;
      out_row_ff   <= out_row_in;
      out_size_ff  <= out_size_in;
      out_num_ff   <= out_num_in;
   end

   assign rsp_tvalid         = out_valid_ff;
   assign rsp_found          = out_found_ff;
   assign rsp_column         = out_col_ff;
   assign rsp_first_row      = out_row_ff;
   assign rsp_run_size       = out_size_ff;
   assign rsp_cluster_number = out_num_ff;

endmodule
`default_nettype wire

// ----- hdl/strip_hit_run_clustering_core.sv -----
// top level of the strip hit run clustering core
//
//   channel | direction | tdata (low bit up)                       | tuser
//   req_    | in        | channel[9:0]                             | action[1:0]
//   rsp_    | out       | column, first_row, run_size, cluster_num | found
//
// a clear empties the map at once through row valid bits
// fetch reads the map one 32-bit word at a time on the single memory read port,
// and skips the scan once the event is exhausted
// reset is synchronous and leaves an empty map with the scan at its start
// a result waits in the output register while the next item is taken
// a fetch holds in its emit cycle until the output register is free
`default_nettype none
module strip_hit_run_clustering_core #(
   parameter int STRIPS_PER_COLUMN = shrc_pkg::STRIPS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // channel[9:0], zero fill
   input  wire logic [1:0]  req_tuser,   // action[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // column[0], first_row[8:1], run_size[17:9],
                                         // cluster_number[25:18], zero fill
   output logic             rsp_tuser    // found
);
   import shrc_pkg::*;

   shrc_cmd_type    cmd;
   shrc_status_type status;
   logic            found, column;
   logic [7:0]      first_row, cluster_number;
   logic [8:0]      run_size;

   shrc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   shrc_datapath #(
      .STRIPS_PER_COLUMN (STRIPS_PER_COLUMN)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .channel            (req_tdata[9:0]),
      .rsp_tready         (rsp_tready),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_found          (found),
      .rsp_column         (column),
      .rsp_first_row      (first_row),
      .rsp_run_size       (run_size),
      .rsp_cluster_number (cluster_number)
   );

   assign rsp_tdata = {6'd0, cluster_number, run_size, first_row, column};
   assign rsp_tuser = found;

endmodule
`default_nettype wire

// ----- hdl/shrc_checker.sv -----
// port-level checker of the strip hit run clustering core and its bind
`default_nettype none
`include "assert_macros.svh"
module shrc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tuser
);
   import shrc_pkg::*;

   logic rsp_wait;
   logic fetch_take;

   assign rsp_wait   = rsp_tvalid && !rsp_tready;
   assign fetch_take = req_tvalid && req_tready && req_tuser == ACT_FETCH;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_tvalid && $stable({rsp_tuser, rsp_tdata}))
   `ASSERT_NEXT(a_fetch_busy, clock, reset, fetch_take, !req_tready)
   `ASSERT_IMPLIES(a_none_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == 32'd0)
   `ASSERT_IMPLIES(a_found_size, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[17:9] != 9'd0)

endmodule

bind strip_hit_run_clustering_core shrc_checker u_shrc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
